FILE: src/vtae_pkg.sv
// Shared types, constants and byte tables for the text cell to terminal encoder.
// No dependencies; every other file in src imports this package.
`default_nettype none

package vtae_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CNT_W   = 8;

    // Depth of the job queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Bytes of the terminal stream
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] LBRACKET   = 8'h5B;
    localparam logic [7:0] SEMICOLON  = 8'h3B;
    localparam logic [7:0] LETTER_M   = 8'h6D;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_1    = 8'h31;
    localparam logic [7:0] DIGIT_3    = 8'h33;
    localparam logic [7:0] DIGIT_4    = 8'h34;
    localparam logic [7:0] NEWLINE    = 8'h0A;

    // One input item: a text cell
    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } cell_t;

    // One result item: a stream byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } byte_out_t;

    // Classified cell handed from front to back
    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       attr_chg;   // emit foreground and background escapes
        logic       row_nl;     // emit reset and newline at row end
        logic       scr_end;    // emit reset at screen end
        logic       scr_nl;     // newline after the screen-end reset
    } job_t;

    // Output segments of one job, one-hot
    typedef enum logic [4:0] {
        SEG_FG   = 5'b00001,
        SEG_BG   = 5'b00010,
        SEG_CHAR = 5'b00100,
        SEG_ROW  = 5'b01000,
        SEG_SCR  = 5'b10000
    } seg_t;

    // PC colour index to ANSI colour index
    function automatic logic [2:0] colour_map(input logic [2:0] pc);
        logic [2:0] res;
        begin
            case (pc)
                3'd0:    res = 3'd0;
                3'd1:    res = 3'd4;
                3'd2:    res = 3'd2;
                3'd3:    res = 3'd6;
                3'd4:    res = 3'd1;
                3'd5:    res = 3'd5;
                3'd6:    res = 3'd3;
                default: res = 3'd7;
            endcase
            return res;
        end
    endfunction

    // Byte at position idx of a colour escape; bright colours carry "1;"
    function automatic logic [7:0] colour_byte(input logic [2:0] idx,
                                               input logic [3:0] nib,
                                               input logic [7:0] tens);
        logic [7:0] digit;
        logic [7:0] res;
        begin
            digit = DIGIT_0 + {5'd0, colour_map(nib[2:0])};
            if (nib[3]) begin
                case (idx)
                    3'd0:    res = ESC_BYTE;
                    3'd1:    res = LBRACKET;
                    3'd2:    res = DIGIT_1;
                    3'd3:    res = SEMICOLON;
                    3'd4:    res = tens;
                    3'd5:    res = digit;
                    default: res = LETTER_M;
                endcase
            end else begin
                case (idx)
                    3'd0:    res = ESC_BYTE;
                    3'd1:    res = LBRACKET;
                    3'd2:    res = tens;
                    3'd3:    res = digit;
                    default: res = LETTER_M;
                endcase
            end
            return res;
        end
    endfunction

    // Byte at position idx of the attribute reset followed by newline
    function automatic logic [7:0] reset_byte(input logic [2:0] idx);
        logic [7:0] res;
        begin
            case (idx)
                3'd0:    res = ESC_BYTE;
                3'd1:    res = LBRACKET;
                3'd2:    res = DIGIT_0;
                3'd3:    res = LETTER_M;
                default: res = NEWLINE;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/vga_text_cell_to_ansi_encoder_core.sv
// Top level of the text cell to terminal byte-stream encoder.
// Depends on vtae_pkg, vtae_front, vtae_queue and vtae_back.
//
// Each accepted cell (character and attribute byte) becomes a run of output
// bytes, one per cycle unless m_ready holds them: foreground and background
// escapes when the attribute differs from the kept one (5 or 7 bytes each),
// the character, then at row ends (newline mode on) and screen ends the reset,
// with a newline in newline mode, up to 25 bytes for one cell; last marks a
// cell's final byte. The output byte rate of the back end sets throughput; a
// plain character causes a single byte. A four-entry job queue lets cells be
// accepted while an earlier cell's bytes are still being sent. newline_enable is
// written over the cfg channel, always ready, and acts from the next accepted cell.
`default_nettype none

module vga_text_cell_to_ansi_encoder_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vtae_pkg::cell_t     s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vtae_pkg::byte_out_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);
    import vtae_pkg::*;

    logic f_valid, f_ready;
    job_t f_job;
    logic b_valid, b_ready;
    job_t b_job;

    assign cfg_ready = 1'b1;

    // Cell classification
    vtae_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_data  (f_job)
    );

    // Job queue
    vtae_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    // Byte emission
    vtae_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job_data  (b_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

FILE: src/vtae_front.sv
// Front end: accepts cells, tracks kept attribute and row/column position,
// and classifies each cell into a job. Depends on vtae_pkg.
`default_nettype none

module vtae_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire vtae_pkg::cell_t s_data,
    input  wire logic            cfg_valid,
    input  wire logic            cfg_data,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output vtae_pkg::job_t       job_data
);
    import vtae_pkg::*;

    logic [7:0]       attr_reg, attr_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             nl_en_reg;
    logic             accept;
    logic             row_end;
    logic             scr_end;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;

    assign row_end = (col_reg == CNT_W'(COLUMNS - 1));
    assign scr_end = row_end && (row_reg == CNT_W'(ROWS - 1));

    // Classification of the incoming cell
    always_comb begin
        job_data.cell_char = s_data.cell_char;
        job_data.cell_attr = s_data.cell_attr;
        job_data.attr_chg  = (s_data.cell_attr != attr_reg);
        job_data.row_nl    = row_end && nl_en_reg;
        job_data.scr_end   = scr_end;
        job_data.scr_nl    = nl_en_reg;
    end

    // Next kept attribute and position
    always_comb begin
        attr_next = s_data.cell_attr;
        if ((row_end && nl_en_reg) || scr_end) begin
            attr_next = 8'd0;
        end
        if (scr_end) begin
            col_next = '0;
            row_next = '0;
        end else if (row_end) begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg  <= 8'd0;
            col_reg   <= '0;
            row_reg   <= '0;
            nl_en_reg <= 1'b1;
        end else begin
            if (accept) begin
                attr_reg <= attr_next;
                col_reg  <= col_next;
                row_reg  <= row_next;
            end
            if (cfg_valid) begin
                nl_en_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/vtae_queue.sv
// Short job queue between front and back, built from registers.
// Depends on vtae_pkg for the job type and depth.
`default_nettype none

module vtae_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire vtae_pkg::job_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output vtae_pkg::job_t      pop_data
);
    import vtae_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/vtae_back.sv
// Back end: walks the segments of each job and emits one byte per cycle into a
// registered output stage while it is not stalled. Depends on vtae_pkg.
`default_nettype none

module vtae_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire vtae_pkg::job_t     job_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output vtae_pkg::byte_out_t     m_data
);
    import vtae_pkg::*;

    job_t       job_reg;
    seg_t       seg_reg;
    seg_t       seg_after;
    logic [2:0] idx_reg;
    logic [2:0] last_idx;
    logic       busy_reg;
    logic       m_valid_reg;
    byte_out_t  m_data_reg;
    logic [7:0] cur_byte;
    logic       has_after;
    logic       seg_done;
    logic       is_last;
    logic       adv;
    logic       load;

    assign adv       = busy_reg && (!m_valid_reg || m_ready);
    assign seg_done  = (idx_reg == last_idx);
    assign is_last   = seg_done && !has_after;
    assign load      = job_valid && (!busy_reg || (adv && is_last));
    assign job_ready = !busy_reg || (adv && is_last);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Current byte, segment length and following segment
    always_comb begin
        cur_byte  = job_reg.cell_char;
        last_idx  = 3'd0;
        seg_after = SEG_CHAR;
        has_after = 1'b0;
        case (seg_reg)
            SEG_FG: begin
                cur_byte  = colour_byte(idx_reg, job_reg.cell_attr[3:0], DIGIT_3);
                last_idx  = job_reg.cell_attr[3] ? 3'd6 : 3'd4;
                seg_after = SEG_BG;
                has_after = 1'b1;
            end
            SEG_BG: begin
                cur_byte  = colour_byte(idx_reg, job_reg.cell_attr[7:4], DIGIT_4);
                last_idx  = job_reg.cell_attr[7] ? 3'd6 : 3'd4;
                seg_after = SEG_CHAR;
                has_after = 1'b1;
            end
            SEG_CHAR: begin
                cur_byte  = job_reg.cell_char;
                last_idx  = 3'd0;
                seg_after = job_reg.row_nl ? SEG_ROW : SEG_SCR;
                has_after = job_reg.row_nl || job_reg.scr_end;
            end
            SEG_ROW: begin
                cur_byte  = reset_byte(idx_reg);
                last_idx  = 3'd4;
                seg_after = SEG_SCR;
                has_after = job_reg.scr_end;
            end
            SEG_SCR: begin
                cur_byte  = reset_byte(idx_reg);
                last_idx  = job_reg.scr_nl ? 3'd4 : 3'd3;
                seg_after = SEG_SCR;
                has_after = 1'b0;
            end
            default: begin
                cur_byte  = job_reg.cell_char;
                last_idx  = 3'd0;
                seg_after = SEG_CHAR;
                has_after = 1'b0;
            end
        endcase
    end

    // Job walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seg_reg  <= SEG_CHAR;
            idx_reg  <= 3'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            seg_reg  <= job_data.attr_chg ? SEG_FG : SEG_CHAR;
            idx_reg  <= 3'd0;
        end else if (adv) begin
            if (seg_done) begin
                seg_reg  <= seg_after;
                idx_reg  <= 3'd0;
                busy_reg <= has_after;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.out_byte <= cur_byte;
            m_data_reg.last     <= is_last;
        end
    end

endmodule

`default_nettype wire

FILE: test/vga_text_cell_to_ansi_encoder_core_tb.sv
// Self-checking testbench for vga_text_cell_to_ansi_encoder_core.
// Drives text cells with random idling, predicts the terminal byte stream and
// checks every output item in order. Depends on vtae_pkg and the core RTL.
`timescale 1ns / 1ps

module vga_text_cell_to_ansi_encoder_core_tb;
    import vtae_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 88;

    // Predicts the byte stream of each accepted cell and checks results in order
    class ansi_stream_predictor;
        logic [7:0] kept_attr;
        int         col;
        int         row;
        bit         nl_on;
        int         errors;
        byte_out_t  expected_bytes[$];
        logic [7:0] burst[$];

        function new();
            kept_attr = '0;
            col       = 0;
            row       = 0;
            nl_on     = 1'b1;
            errors    = 0;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // ESC [ (1;) tens digit m, digit from the PC-to-ANSI colour order
        function void add_colour(logic [3:0] nib, logic [7:0] tens_digit);
            logic [2:0] ansi;
            case (nib[2:0])
                3'd0:    ansi = 3'd0;
                3'd1:    ansi = 3'd4;
                3'd2:    ansi = 3'd2;
                3'd3:    ansi = 3'd6;
                3'd4:    ansi = 3'd1;
                3'd5:    ansi = 3'd5;
                3'd6:    ansi = 3'd3;
                default: ansi = 3'd7;
            endcase
            burst.push_back(ESC_BYTE);
            burst.push_back(LBRACKET);
            if (nib[3]) begin
                burst.push_back(DIGIT_1);
                burst.push_back(SEMICOLON);
            end
            burst.push_back(tens_digit);
            burst.push_back(DIGIT_0 + {5'd0, ansi});
            burst.push_back(LETTER_M);
        endfunction

        function void add_reset();
            burst.push_back(ESC_BYTE);
            burst.push_back(LBRACKET);
            burst.push_back(DIGIT_0);
            burst.push_back(LETTER_M);
        endfunction

        function void take_cell(cell_t c_in);
            bit        row_end;
            bit        scr_end;
            byte_out_t b;
            burst.delete();
            // attribute change: foreground then background escape
            if (c_in.cell_attr != kept_attr) begin
                kept_attr = c_in.cell_attr;
                add_colour(c_in.cell_attr[3:0], DIGIT_3);
                add_colour(c_in.cell_attr[7:4], DIGIT_4);
            end
            burst.push_back(c_in.cell_char);

            row_end = (col + 1 >= COLUMNS);
            scr_end = row_end && (row + 1 >= ROWS);
            if (row_end && nl_on) begin
                add_reset();
                kept_attr = '0;
                burst.push_back(NEWLINE);
            end
            // screen end: reset, optional newline, wrap to the first cell
            if (scr_end) begin
                add_reset();
                if (nl_on) begin
                    burst.push_back(NEWLINE);
                end
                kept_attr = '0;
                col       = 0;
                row       = 0;
            end else if (row_end) begin
                col = 0;
                row++;
            end else begin
                col++;
            end

            for (int k = 0; k < burst.size(); k++) begin
                b.out_byte = burst[k];
                b.last     = (k == burst.size() - 1);
                expected_bytes.push_back(b);
            end
        endfunction

        task check_byte(byte_out_t got);
            byte_out_t want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          got.out_byte, got.last));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                          got.out_byte, want.out_byte));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last %0b, predicted %0b (byte %02h)",
                                          got.last, want.last, want.out_byte));
            end
        endtask
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    cell_t     s_data    = '0;
    logic      m_ready   = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      s_ready;
    logic      m_valid;
    byte_out_t m_data;
    logic      cfg_ready;

    ansi_stream_predictor board = new();

    int         idle_pct  = 0;
    int         stall_pct = 0;
    bit         hold_req  = 1'b0;
    int         cycles    = 0;
    logic [7:0] last_attr = '0;

    vga_text_cell_to_ansi_encoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("vga_text_cell_to_ansi_encoder_core: mismatch");
            $finish;
        end
    end

    // Handshake monitor: register writes, accepted cells, output bytes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                board.nl_on = cfg_data;
            end
            if (s_valid && s_ready) begin
                board.take_cell(s_data);
            end
            if (m_valid && m_ready) begin
                board.check_byte(m_data);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_cell(input logic [7:0] ch, input logic [7:0] at);
        cell_t c_in;
        c_in.cell_char = ch;
        c_in.cell_attr = at;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= c_in;
        do @(posedge aclk); while (!s_ready);
        last_attr = at;
    endtask

    task automatic end_stream();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (board.expected_bytes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_newline(input logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Runs of one attribute with occasional changes and black resets
    task automatic random_items(input int n);
        int         r;
        logic [7:0] at;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                at = last_attr;
            end else if (r < 65) begin
                at = '0;
            end else begin
                at = $urandom_range(255);
            end
            send_cell($urandom_range(255), at);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_newline(1'b1);

        // Directed: black first cell, all-ones, repeated attribute, every nibble
        send_cell(8'h00, 8'h00);
        send_cell(8'hFF, 8'hFF);
        send_cell(8'h41, 8'h07);
        send_cell(8'h42, 8'h07);
        for (int k = 0; k < 16; k++) begin
            send_cell(8'h20 + k[7:0], {4'(15 - k), 4'(k)});
        end
        end_stream();
        wait_idle();

        // Random phases, newline mode toggled mid-screen between them
        for (int p = 0; p < 4; p++) begin
            set_newline(p[0]);
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 47; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            random_items(PHASE_ITEMS);
            end_stream();
            wait_idle();
        end

        // Back-pressure: receiver holds off while cells keep coming
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        random_items(40);
        end_stream();
        wait_idle();

        // Newline mode written on once more, light idling on both sides
        stall_pct = 16;
        idle_pct  = 16;
        set_newline(1'b1);
        random_items(20);
        end_stream();
        wait_idle();

        if (board.errors == 0 && board.expected_bytes.size() == 0) begin
            $display("vga_text_cell_to_ansi_encoder_core: match");
        end else begin
            $display("vga_text_cell_to_ansi_encoder_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/vtae_pkg.sv
src/vtae_front.sv
src/vtae_queue.sv
src/vtae_back.sv
src/vga_text_cell_to_ansi_encoder_core.sv
test/vga_text_cell_to_ansi_encoder_core_tb.sv
